// ----- hw/rtl/tftp_rx_pkg.sv -----
// Package: types and constants shared by the TFTP data receiver modules
`default_nettype none
package tftp_rx_pkg;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        end_of_datagram;
    logic [15:0] sender_port;
    logic [31:0] sender_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] buffer_position;
    logic [7:0]  data_byte;
    logic [31:0] flash_address;
    logic [11:0] commit_length;
    logic [15:0] block_number;
    logic [15:0] dest_port;
    logic [31:0] dest_ip;
    logic [15:0] error_code;
    logic        download_done;
    logic        last;
  } out_item_t;

  // Work handed from front to back: up to three results per request.
  typedef struct packed {
    logic        store_en;
    logic [10:0] store_pos;
    logic [7:0]  store_byte;
    logic        commit_en;
    logic [31:0] commit_addr;
    logic [11:0] commit_len;
    logic        ack_en;
    logic [15:0] ack_block;
    logic [15:0] ack_port;
    logic [31:0] ack_ip;
    logic        err_en;
    logic [15:0] err_code;
    logic        done;
  } work_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tftp_rx_front.sv -----
// Front end: parses datagram bytes, tracks transfer state, builds work entries
`default_nettype none
module tftp_rx_front import tftp_rx_pkg::*; #(
  parameter int BLOCK_BYTES = 512,
  parameter int PAGE_BYTES  = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [31:0] cfg_data,
  input  wire logic        take,
  input  wire in_item_t    item,
  output work_t            work
);

  localparam int BPP_RAW = PAGE_BYTES / BLOCK_BYTES;
  localparam int BPP     = (BPP_RAW > 0) ? BPP_RAW : 1;
  localparam int MW      = (BPP > 1) ? $clog2(BPP) : 1;
  localparam logic [MW-1:0] PHASE_TOP = MW'(BPP - 1);
  localparam int BCW     = $clog2(BLOCK_BYTES + 2);
  localparam logic [BCW-1:0] BLK_FULL = BCW'(BLOCK_BYTES);
  localparam logic [BCW-1:0] BLK_OVER = BCW'(BLOCK_BYTES + 1);

  logic [9:0]     byte_count;
  logic [15:0]    opcode_word;
  logic [15:0]    header_word;
  logic           block_in_order;
  logic [15:0]    accepted_block;
  logic [MW-1:0]  block_phase;
  logic [11:0]    page_fill;
  logic [BCW-1:0] block_data_count;
  logic [31:0]    write_address;
  logic [31:0]    base_flash_address;
  logic [15:0]    peer_port;
  logic           done_flag;

  logic [15:0]    hdr_now;
  logic [15:0]    op_now;
  logic           in_order_now;
  logic [BCW-1:0] bdc_now;
  logic [15:0]    peer_now;
  logic [MW-1:0]  phase_next;
  logic [11:0]    stored;
  logic [11:0]    fill_sum;
  logic           shortb;
  logic           boundary;
  logic           data_end;
  work_t          w;

  always_comb begin
    w = '0;
    op_now = opcode_word;
    hdr_now = header_word;
    in_order_now = block_in_order;
    bdc_now = block_data_count;
    peer_now = (byte_count == 10'd0 && peer_port == 16'd0) ? item.sender_port : peer_port;
    case (byte_count)
      10'd0: op_now = {item.payload_byte, 8'd0};
      10'd1: op_now = {opcode_word[15:8], item.payload_byte};
      10'd2: hdr_now = {item.payload_byte, 8'd0};
      10'd3: begin
        hdr_now = {header_word[15:8], item.payload_byte};
        in_order_now = (opcode_word == OP_DATA) && (hdr_now == accepted_block + 16'd1);
      end
      default: begin
        if (block_in_order) begin
          if (block_data_count < BLK_FULL) begin
            w.store_en = 1'b1;
            w.store_pos = 11'(page_fill + 12'(block_data_count));
            w.store_byte = item.payload_byte;
            bdc_now = block_data_count + 1'b1;
          end else begin
            bdc_now = BLK_OVER;
          end
        end
      end
    endcase
    stored = (bdc_now > BLK_FULL) ? 12'(BLOCK_BYTES) : 12'(bdc_now);
    fill_sum = page_fill + stored;
    shortb = bdc_now != BLK_FULL;
    phase_next = (accepted_block == 16'hffff || block_phase == PHASE_TOP) ? '0 :
                 MW'(block_phase + 1'b1);
    boundary = phase_next == '0;
    data_end = item.end_of_datagram && byte_count >= 10'd3 && op_now == OP_DATA;
    if (data_end) begin
      w.ack_en = 1'b1;
      w.ack_port = peer_now;
      w.ack_ip = item.sender_ip;
      w.ack_block = in_order_now ? hdr_now : accepted_block;
      if (in_order_now && (boundary || shortb)) begin
        w.commit_en = 1'b1;
        w.commit_addr = write_address;
        w.commit_len = fill_sum;
      end
    end
    if (item.end_of_datagram && byte_count >= 10'd3 && op_now == OP_ERROR) begin
      w.err_en = 1'b1;
      w.err_code = hdr_now;
    end
    w.done = done_flag || (data_end && in_order_now && shortb);
  end

  assign work = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      opcode_word <= '0;
      header_word <= '0;
      block_in_order <= 1'b0;
      accepted_block <= '0;
      block_phase <= '0;
      page_fill <= '0;
      block_data_count <= '0;
      write_address <= '0;
      base_flash_address <= '0;
      peer_port <= '0;
      done_flag <= 1'b0;
    end else if (cfg_valid) begin
      base_flash_address <= cfg_data;
      write_address <= cfg_data;
    end else if (take) begin
      peer_port <= peer_now;
      done_flag <= w.done;
      if (byte_count < 10'd1023) byte_count <= byte_count + 10'd1;
      opcode_word <= op_now;
      header_word <= hdr_now;
      block_in_order <= in_order_now;
      block_data_count <= bdc_now;
      if (item.end_of_datagram) begin
        byte_count <= '0;
        opcode_word <= '0;
        header_word <= '0;
        block_in_order <= 1'b0;
        block_data_count <= '0;
        if (data_end && in_order_now) begin
          accepted_block <= hdr_now;
          block_phase <= phase_next;
          if (shortb) begin
            write_address <= base_flash_address;
            page_fill <= '0;
          end else if (boundary) begin
            write_address <= write_address + 32'(fill_sum);
            page_fill <= '0;
          end else begin
            page_fill <= fill_sum;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tftp_rx_queue.sv -----
// Short queue of work entries between front and back
`default_nettype none
module tftp_rx_queue import tftp_rx_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire work_t wr_data,
  output logic       full,
  input  wire logic  rd,
  output logic       empty,
  output work_t      rd_data
);

  work_t      mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;

  assign full = count == 3'd4;
  assign empty = count == 3'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      count <= count + 3'(wr) - 3'(rd);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tftp_rx_back.sv -----
// Back end: expands each work entry into its result requests, one per pop
`default_nettype none
module tftp_rx_back import tftp_rx_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire work_t q_data,
  output logic       q_rd,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  result
);

  logic [2:0] sent;
  logic [2:0] pend;
  logic [2:0] sel;
  logic       last_one;
  out_item_t  r;

  always_comb begin
    pend = {q_data.store_en, q_data.commit_en, q_data.ack_en | q_data.err_en} & ~sent;
    if (pend[2]) sel = 3'b100;
    else if (pend[1]) sel = 3'b010;
    else if (pend[0]) sel = 3'b001;
    else sel = 3'b000;
    last_one = (pend & ~sel) == 3'd0;
    r = '0;
    r.download_done = q_data.done;
    r.last = last_one;
    if (sel[2]) begin
      r.kind = KIND_STORE;
      r.buffer_position = q_data.store_pos;
      r.data_byte = q_data.store_byte;
    end else if (sel[1]) begin
      r.kind = KIND_COMMIT;
      r.flash_address = q_data.commit_addr;
      r.commit_length = q_data.commit_len;
    end else if (q_data.ack_en) begin
      r.kind = KIND_ACK;
      r.block_number = q_data.ack_block;
      r.dest_port = q_data.ack_port;
      r.dest_ip = q_data.ack_ip;
    end else begin
      r.kind = KIND_ERROR;
      r.error_code = q_data.err_code;
    end
  end

  assign empty = q_empty || pend == 3'd0;
  assign result = r;
  assign q_rd = !q_empty && (pend == 3'd0 || (pop && last_one));

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (q_rd) begin
      sent <= '0;
    end else if (pop && !empty) begin
      sent <= sent | sel;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tftp_data_receiver_top.sv -----
// Top level of the TFTP data receiver
//
//  channel  | handshake         | payload
//  input    | push / full       | in_item (in_item_t)
//  result   | pop / empty       | result (out_item_t)
//  config   | cfg_valid / ready | cfg_data, base flash address
//
// One byte accepted per cycle while full is low; each yields zero to three results, one per pop.
// Results appear the cycle after the byte at the earliest (queue, then back end).
// full rises when the four-entry work queue fills; pops drain it independently.
// cfg_ready is low while push is high, so a register write never meets a byte.
// Synchronous reset clears all state but the queue storage; write address starts at zero.
`default_nettype none
module tftp_data_receiver_top import tftp_rx_pkg::*; #(
  parameter int BLOCK_BYTES = 512,
  parameter int PAGE_BYTES  = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  work_t w_in;
  work_t w_out;
  logic  take;
  logic  cfg_we;
  logic  q_empty;
  logic  q_rd;

  assign take = push && !full;
  assign cfg_ready = !push;
  assign cfg_we = cfg_valid && cfg_ready;

  tftp_rx_front #(.BLOCK_BYTES(BLOCK_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst, .cfg_valid(cfg_we), .cfg_data, .take, .item(in_item), .work(w_in)
  );

  tftp_rx_queue u_queue (
    .clk, .rst, .wr(take), .wr_data(w_in), .full,
    .rd(q_rd), .empty(q_empty), .rd_data(w_out)
  );

  tftp_rx_back u_back (
    .clk, .rst, .q_empty, .q_data(w_out), .q_rd, .empty, .pop, .result
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tftp_rx_checker.sv -----
// Port checker for the TFTP data receiver, bound to the top level
`default_nettype none
module tftp_rx_checker import tftp_rx_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result)) else $error("result dropped while stalled");

  a_store_len: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_STORE |->
      result.flash_address == 32'd0 && result.commit_length == 12'd0)
    else $error("store carries commit fields");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && result.download_done |=> empty || result.download_done)
    else $error("done flag cleared");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_ACK |-> result.last && result.data_byte == 8'd0)
    else $error("ack not last");

endmodule

bind tftp_data_receiver_top tftp_rx_checker u_checker (
  .clk, .rst, .empty, .pop, .result
);
`default_nettype wire
